@@ src/i2c_mbe_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2c_mbe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_ST_B   = 5'd2,
    PH_ST_C   = 5'd3,
    PH_SP_A   = 5'd4,
    PH_SP_B   = 5'd5,
    PH_SP_C   = 5'd6,
    PH_WR_LO  = 5'd7,
    PH_WR_HI  = 5'd8,
    PH_WA_LO  = 5'd9,
    PH_WA_HI  = 5'd10,
    PH_RD_LO  = 5'd11,
    PH_RD_HI  = 5'd12,
    PH_RA_LO  = 5'd13,
    PH_RA_HI  = 5'd14,
    PH_RN_LO  = 5'd15,
    PH_RN_HI  = 5'd16,
    PH_RDN_LO = 5'd17,
    PH_RDN_HI = 5'd18
  } phase_e;

  // One queued tick: the command already decoded, unknown codes folded to none.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } q_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       write_failed;
  } out_item_t;

endpackage

@@ src/i2c_mbe_if.sv @@
// Handshake channel interfaces for ticks, results and register writes.
`timescale 1ns / 1ps

interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, cmd, tx_byte, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, sda_in, output ready);
endinterface

interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_bit;
  logic       write_failed;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
                  write_failed, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
                  write_failed, output ready);
endinterface

interface i2c_mbe_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [i2c_mbe_pkg::CFG_IDX_W-1:0]   index;
  logic [i2c_mbe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/i2c_mbe_front.sv @@
// Front end: takes tick beats and decodes the command field for the queue.
`timescale 1ns / 1ps

module i2c_mbe_front (
  i2c_mbe_in_if.sink            in_i,
  output logic                  push_valid_o,
  output i2c_mbe_pkg::q_item_t  push_item_o,
  input  logic                  push_ready_i
);
  import i2c_mbe_pkg::*;

  cmd_e cmd_dec;

  always_comb begin
    case (in_i.cmd)
      CMD_START:     cmd_dec = CMD_START;
      CMD_STOP:      cmd_dec = CMD_STOP;
      CMD_WRITE:     cmd_dec = CMD_WRITE;
      CMD_READ_ACK:  cmd_dec = CMD_READ_ACK;
      CMD_READ_NACK: cmd_dec = CMD_READ_NACK;
      default:       cmd_dec = CMD_NONE;
    endcase
  end

  assign push_valid_o        = in_i.valid;
  assign push_item_o.cmd     = cmd_dec;
  assign push_item_o.tx_byte = in_i.tx_byte;
  assign push_item_o.sda_in  = in_i.sda_in;
  assign in_i.ready          = push_ready_i;

endmodule

@@ src/i2c_mbe_fifo.sv @@
// Short queue of decoded tick beats between the front and back ends.
`timescale 1ns / 1ps

module i2c_mbe_fifo #(
  parameter int unsigned Depth = i2c_mbe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  i2c_mbe_pkg::q_item_t  push_item_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output i2c_mbe_pkg::q_item_t  pop_item_o,
  input  logic                  pop_ready_i
);
  import i2c_mbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_item_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ src/i2c_mbe_back.sv @@
// Back end: bus phase sequencer, configuration registers and result register.
`timescale 1ns / 1ps

module i2c_mbe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  i2c_mbe_cfg_if.sink           cfg_i,
  input  logic                  pop_valid_i,
  input  i2c_mbe_pkg::q_item_t  pop_item_i,
  output logic                  pop_ready_o,
  i2c_mbe_out_if.source         out_o
);
  import i2c_mbe_pkg::*;

  logic [15:0] half_period_q, half_period_d;
  logic [3:0]  retry_limit_q, retry_limit_d;

  phase_e      phase_q, phase_d, phase_cur;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  attempt_q, attempt_d;
  logic [7:0]  saved_q, saved_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic        fail_q, fail_d;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        step;
  logic        scl_now, sda_now, done_now;
  logic [15:0] hp_eff;
  logic [3:0]  lim_eff;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign step        = pop_valid_i && pop_ready_o;
  assign hp_eff      = (half_period_q == '0) ? 16'd1 : half_period_q;
  assign lim_eff     = (retry_limit_q == '0) ? 4'd1 : retry_limit_q;
  assign cfg_i.ready = 1'b1;

  // Bit of the byte under transmission selected by the low three count bits.
  function automatic logic tx_bit(input logic [7:0] byte_v, input logic [3:0] cnt);
    return byte_v[~cnt[2:0]];
  endfunction

  always_comb begin
    half_period_d = half_period_q;
    retry_limit_d = retry_limit_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HALF_PERIOD: half_period_d = cfg_i.data;
        REG_RETRY_LIMIT: retry_limit_d = cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // Next state: optional command start, then one tick of the current phase.
  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    tick_d      = tick_q;
    attempt_d   = attempt_q;
    saved_d     = saved_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    ack_d       = ack_q;
    fail_d      = fail_q;
    scl_now     = scl_q;
    sda_now     = sda_q;
    done_now    = 1'b0;
    phase_cur   = phase_q;

    if (step) begin
      if (phase_q == PH_IDLE && pop_item_i.cmd != CMD_NONE) begin
        bit_count_d = '0;
        tick_d      = '0;
        case (pop_item_i.cmd)
          CMD_START: begin
            phase_d = PH_ST_A;
            sda_d   = 1'b1;
          end
          CMD_STOP: begin
            phase_d = PH_SP_A;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
          end
          CMD_WRITE: begin
            saved_d   = pop_item_i.tx_byte;
            attempt_d = '0;
            fail_d    = 1'b0;
            phase_d   = PH_WR_LO;
            scl_d     = 1'b0;
            sda_d     = pop_item_i.tx_byte[7];
          end
          CMD_READ_ACK: begin
            saved_d = '0;
            phase_d = PH_RD_LO;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
          end
          CMD_READ_NACK: begin
            saved_d = '0;
            phase_d = PH_RDN_LO;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
          end
          default: ;
        endcase
      end

      scl_now   = scl_d;
      sda_now   = sda_d;
      phase_cur = phase_d;

      if (phase_cur != PH_IDLE) begin
        tick_d = tick_d + 1'b1;
        if (tick_d >= hp_eff) begin
          // Every phase change restarts the tick counter.
          tick_d = '0;
          case (phase_cur)
            PH_ST_A: begin phase_d = PH_ST_B; scl_d = 1'b1; sda_d = 1'b1; end
            PH_ST_B: begin phase_d = PH_ST_C; scl_d = 1'b1; sda_d = 1'b0; end
            PH_ST_C: begin
              phase_d = PH_IDLE; scl_d = 1'b0; sda_d = 1'b0; done_now = 1'b1;
            end
            PH_SP_A: begin phase_d = PH_SP_B; scl_d = 1'b1; sda_d = 1'b0; end
            PH_SP_B: begin phase_d = PH_SP_C; scl_d = 1'b1; sda_d = 1'b1; end
            PH_SP_C: begin
              phase_d = PH_IDLE; scl_d = 1'b1; sda_d = 1'b1; done_now = 1'b1;
            end
            PH_WR_LO: begin
              phase_d = PH_WR_HI;
              scl_d   = 1'b1;
              sda_d   = tx_bit(saved_d, bit_count_d);
            end
            PH_WR_HI: begin
              bit_count_d = bit_count_d + 1'b1;
              scl_d       = 1'b0;
              if (bit_count_d < BITS_PER_BYTE) begin
                phase_d = PH_WR_LO;
                sda_d   = tx_bit(saved_d, bit_count_d);
              end else begin
                phase_d = PH_WA_LO;
                sda_d   = 1'b1;
              end
            end
            PH_WA_LO: begin phase_d = PH_WA_HI; scl_d = 1'b1; sda_d = 1'b1; end
            PH_WA_HI: begin
              ack_d = pop_item_i.sda_in;
              scl_d = 1'b0;
              if (!pop_item_i.sda_in) begin
                phase_d = PH_IDLE; sda_d = 1'b1; done_now = 1'b1;
              end else begin
                attempt_d = attempt_d + 1'b1;
                if (attempt_d >= lim_eff) begin
                  fail_d   = 1'b1;
                  phase_d  = PH_IDLE;
                  sda_d    = 1'b1;
                  done_now = 1'b1;
                end else begin
                  // Resend the same byte without a new start condition.
                  bit_count_d = '0;
                  phase_d     = PH_WR_LO;
                  sda_d       = saved_d[7];
                end
              end
            end
            PH_RD_LO:  begin phase_d = PH_RD_HI;  scl_d = 1'b1; sda_d = 1'b1; end
            PH_RDN_LO: begin phase_d = PH_RDN_HI; scl_d = 1'b1; sda_d = 1'b1; end
            PH_RD_HI, PH_RDN_HI: begin
              saved_d     = {saved_d[6:0], pop_item_i.sda_in};
              bit_count_d = bit_count_d + 1'b1;
              scl_d       = 1'b0;
              sda_d       = 1'b1;
              if (bit_count_d < BITS_PER_BYTE) begin
                phase_d = (phase_cur == PH_RDN_HI) ? PH_RDN_LO : PH_RD_LO;
              end else if (phase_cur == PH_RDN_HI) begin
                phase_d = PH_RN_LO;
              end else begin
                phase_d = PH_RA_LO;
                sda_d   = 1'b0;
              end
            end
            PH_RA_LO: begin phase_d = PH_RA_HI; scl_d = 1'b1; sda_d = 1'b0; end
            PH_RN_LO: begin phase_d = PH_RN_HI; scl_d = 1'b1; sda_d = 1'b1; end
            PH_RA_HI, PH_RN_HI: begin
              shift_d  = saved_d;
              phase_d  = PH_IDLE;
              scl_d    = 1'b0;
              sda_d    = 1'b1;
              done_now = 1'b1;
            end
            default: begin
              phase_d  = PH_IDLE;
              done_now = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Result beat for the tick just carried out.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d        = 1'b1;
      out_d.scl_out      = scl_now;
      out_d.sda_out      = sda_now;
      out_d.busy_res     = (phase_d != PH_IDLE);
      out_d.done_res     = done_now;
      out_d.rx_byte      = shift_d;
      out_d.ack_bit      = ack_d;
      out_d.write_failed = fail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
      phase_q       <= PH_IDLE;
      bit_count_q   <= '0;
      shift_q       <= '0;
      tick_q        <= '0;
      attempt_q     <= '0;
      saved_q       <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      ack_q         <= 1'b0;
      fail_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      half_period_q <= half_period_d;
      retry_limit_q <= retry_limit_d;
      phase_q       <= phase_d;
      bit_count_q   <= bit_count_d;
      shift_q       <= shift_d;
      tick_q        <= tick_d;
      attempt_q     <= attempt_d;
      saved_q       <= saved_d;
      scl_q         <= scl_d;
      sda_q         <= sda_d;
      ack_q         <= ack_d;
      fail_q        <= fail_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.scl_out      = out_q.scl_out;
  assign out_o.sda_out      = out_q.sda_out;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.done_res     = out_q.done_res;
  assign out_o.rx_byte      = out_q.rx_byte;
  assign out_o.ack_bit      = out_q.ack_bit;
  assign out_o.write_failed = out_q.write_failed;

endmodule

@@ src/i2c_master_bit_engine.sv @@
// Path: an accepted tick beat is written into the queue, then the back end pops it and
// registers its result beat, which the result register holds until it is taken.
// Throughput: one tick per cycle while results are taken; the back end's phase sequencer
// retires one queued tick per cycle, and while a result waits the two-entry queue fills up.
// Reset: asynchronous, active low; phase idle, both bus lines released high,
// half period 2, retry limit 5, queue empty, no result pending.
`timescale 1ns / 1ps

module i2c_master_bit_engine #(
  parameter int unsigned QueueDepth = i2c_mbe_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2c_mbe_in_if.sink    in_i,
  i2c_mbe_cfg_if.sink   cfg_i,
  i2c_mbe_out_if.source out_o
);
  import i2c_mbe_pkg::*;

  logic    push_valid, push_ready;
  logic    pop_valid, pop_ready;
  q_item_t push_item, pop_item;

  i2c_mbe_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  i2c_mbe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  i2c_mbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

@@ test/i2c_master_bit_engine_checker.sv @@
// Checker for the I2C master bit engine: predicts each result beat and compares it.
`timescale 1ns / 1ps

module i2c_master_bit_engine_checker
  import i2c_mbe_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  i2c_mbe_in_if  tick_mon_i,
  i2c_mbe_cfg_if cfg_mon_i,
  i2c_mbe_out_if res_mon_i,
  output int     mismatches_o,
  output int     waiting_o,
  output int     ticks_o,
  output logic   line_busy_o,
  output int     cmds_done_o,
  output int     write_fails_o
);

  // Configuration and line state as the engine should hold them.
  logic [15:0] half_q;
  logic [3:0]  retry_q;
  phase_e      ph_q;
  logic [3:0]  bits_q;
  logic [7:0]  rx_q;
  logic [15:0] phase_ticks_q;
  logic [3:0]  tries_q;
  logic [7:0]  byte_q;
  logic        scl_q;
  logic        sda_q;
  logic        ack_q;
  logic        fail_q;
  logic        done_q;

  out_item_t   line_results_q[$];

  function automatic void enter_phase(phase_e p, logic scl, logic sda);
    ph_q          = p;
    scl_q         = scl;
    sda_q         = sda;
    phase_ticks_q = '0;
  endfunction

  function automatic void finish_cmd(logic scl, logic sda);
    enter_phase(PH_IDLE, scl, sda);
    done_q = 1'b1;
    cmds_done_o++;
  endfunction

  function automatic logic next_tx_bit();
    return byte_q[3'd7 - bits_q[2:0]];
  endfunction

  function automatic void close_phase(logic sda);
    logic       nack_rd;
    logic [3:0] lim;
    nack_rd = (ph_q >= PH_RDN_LO);
    lim     = (retry_q == 4'd0) ? 4'd1 : retry_q;
    case (ph_q)
      PH_ST_A:  enter_phase(PH_ST_B, 1'b1, 1'b1);
      PH_ST_B:  enter_phase(PH_ST_C, 1'b1, 1'b0);
      PH_ST_C:  finish_cmd(1'b0, 1'b0);
      PH_SP_A:  enter_phase(PH_SP_B, 1'b1, 1'b0);
      PH_SP_B:  enter_phase(PH_SP_C, 1'b1, 1'b1);
      PH_SP_C:  finish_cmd(1'b1, 1'b1);
      PH_WR_LO: enter_phase(PH_WR_HI, 1'b1, next_tx_bit());
      PH_WR_HI: begin
        bits_q = bits_q + 4'd1;
        if (bits_q < BITS_PER_BYTE) enter_phase(PH_WR_LO, 1'b0, next_tx_bit());
        else enter_phase(PH_WA_LO, 1'b0, 1'b1);
      end
      PH_WA_LO: enter_phase(PH_WA_HI, 1'b1, 1'b1);
      PH_WA_HI: begin
        ack_q = sda;
        if (!sda) begin
          finish_cmd(1'b0, 1'b1);
        end else begin
          tries_q = tries_q + 4'd1;
          if (tries_q >= lim) begin
            fail_q = 1'b1;
            write_fails_o++;
            finish_cmd(1'b0, 1'b1);
          end else begin
            // Resend the same byte without a fresh start condition.
            bits_q = '0;
            enter_phase(PH_WR_LO, 1'b0, next_tx_bit());
          end
        end
      end
      PH_RD_LO:  enter_phase(PH_RD_HI, 1'b1, 1'b1);
      PH_RDN_LO: enter_phase(PH_RDN_HI, 1'b1, 1'b1);
      PH_RD_HI, PH_RDN_HI: begin
        byte_q = {byte_q[6:0], sda};
        bits_q = bits_q + 4'd1;
        if (bits_q < BITS_PER_BYTE) enter_phase(nack_rd ? PH_RDN_LO : PH_RD_LO, 1'b0, 1'b1);
        else if (nack_rd) enter_phase(PH_RN_LO, 1'b0, 1'b1);
        else enter_phase(PH_RA_LO, 1'b0, 1'b0);
      end
      PH_RA_LO: enter_phase(PH_RA_HI, 1'b1, 1'b0);
      PH_RN_LO: enter_phase(PH_RN_HI, 1'b1, 1'b1);
      PH_RA_HI, PH_RN_HI: begin
        rx_q = byte_q;
        finish_cmd(1'b0, 1'b1);
      end
      default: finish_cmd(scl_q, sda_q);
    endcase
  endfunction

  function automatic out_item_t bus_tick(logic [2:0] cmd, logic [7:0] tx, logic sda);
    out_item_t   r;
    logic [15:0] hp;
    hp     = (half_q == 16'd0) ? 16'd1 : half_q;
    done_q = 1'b0;
    if (ph_q == PH_IDLE && cmd >= CMD_START && cmd <= CMD_READ_NACK) begin
      bits_q = '0;
      case (cmd)
        CMD_START: enter_phase(PH_ST_A, scl_q, 1'b1);
        CMD_STOP:  enter_phase(PH_SP_A, 1'b0, 1'b0);
        CMD_WRITE: begin
          byte_q  = tx;
          tries_q = '0;
          fail_q  = 1'b0;
          enter_phase(PH_WR_LO, 1'b0, next_tx_bit());
        end
        CMD_READ_ACK: begin
          byte_q = '0;
          enter_phase(PH_RD_LO, 1'b0, 1'b1);
        end
        default: begin
          byte_q = '0;
          enter_phase(PH_RDN_LO, 1'b0, 1'b1);
        end
      endcase
    end
    // The lines show the levels set before this tick's phase end.
    r.scl_out = scl_q;
    r.sda_out = sda_q;
    if (ph_q != PH_IDLE) begin
      phase_ticks_q = phase_ticks_q + 16'd1;
      if (phase_ticks_q >= hp) close_phase(sda);
    end
    r.busy_res     = (ph_q != PH_IDLE);
    r.done_res     = done_q;
    r.rx_byte      = rx_q;
    r.ack_bit      = ack_q;
    r.write_failed = fail_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      half_q        = HALF_PERIOD_RST;
      retry_q       = RETRY_LIMIT_RST;
      ph_q          = PH_IDLE;
      bits_q        = '0;
      rx_q          = '0;
      phase_ticks_q = '0;
      tries_q       = '0;
      byte_q        = '0;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      ack_q         = 1'b0;
      fail_q        = 1'b0;
      done_q        = 1'b0;
      line_results_q.delete();
      mismatches_o  = 0;
      waiting_o     = 0;
      ticks_o       = 0;
      line_busy_o   = 1'b0;
      cmds_done_o   = 0;
      write_fails_o = 0;
    end else begin
      // A result beat always belongs to a tick taken at an earlier edge.
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (line_results_q.size() == 0) begin
          $error("result beat arrived with no tick outstanding");
          mismatches_o++;
        end else begin
          want = line_results_q.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(res_mon_i.scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(res_mon_i.sda_out));
          check_field("busy_res", 8'(want.busy_res), 8'(res_mon_i.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(res_mon_i.done_res));
          check_field("rx_byte", want.rx_byte, res_mon_i.rx_byte);
          check_field("ack_bit", 8'(want.ack_bit), 8'(res_mon_i.ack_bit));
          check_field("write_failed", 8'(want.write_failed), 8'(res_mon_i.write_failed));
        end
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          REG_HALF_PERIOD: half_q = cfg_mon_i.data;
          default:         retry_q = cfg_mon_i.data[3:0];
        endcase
      end
      if (tick_mon_i.valid && tick_mon_i.ready) begin
        line_results_q.push_back(bus_tick(tick_mon_i.cmd, tick_mon_i.tx_byte, tick_mon_i.sda_in));
        ticks_o++;
      end
      line_busy_o = (ph_q != PH_IDLE);
      waiting_o   = line_results_q.size();
    end
  end

endmodule

@@ test/i2c_master_bit_engine_tb.sv @@
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
  import i2c_mbe_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int          PhaseTicks = 360;

  localparam logic [2:0]  CmdBadLow  = 3'd6;
  localparam logic [2:0]  CmdBadHigh = 3'd7;

  // How the simulated slave drives SDA during a command.
  localparam int SlaveNack  = 0;
  localparam int SlaveAck   = 1;
  localparam int SlaveNoisy = 2;
  localparam int SlaveAny   = -1;

  logic clk;
  logic rst_n;

  i2c_mbe_in_if  tick_if ();
  i2c_mbe_cfg_if cfg_if ();
  i2c_mbe_out_if res_if ();

  int   mismatches;
  int   waiting;
  int   ticks_taken;
  int   cmds_done;
  int   write_fails;
  logic line_busy;

  int   ticks_sent;
  int   burst_left;
  int   settings;
  logic in_held;
  logic steady;
  int   slave_mode;

  i2c_master_bit_engine u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .cfg_i  (cfg_if),
    .out_o  (res_if)
  );

  i2c_master_bit_engine_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .tick_mon_i    (tick_if),
    .cfg_mon_i     (cfg_if),
    .res_mon_i     (res_if),
    .mismatches_o  (mismatches),
    .waiting_o     (waiting),
    .ticks_o       (ticks_taken),
    .line_busy_o   (line_busy),
    .cmds_done_o   (cmds_done),
    .write_fails_o (write_fails)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: ready follows one of four stall modes, picked anew at random.
  initial begin : rx_pattern
    int mode;
    int left;
    int period;
    int count;
    res_if.ready <= 1'b0;
    mode   = 0;
    left   = 0;
    period = 2;
    count  = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode   = $urandom_range(0, 3);
        left   = $urandom_range(64, 256);
        period = $urandom_range(2, 5);
      end
      left--;
      count++;
      if (steady || mode == 0) res_if.ready <= 1'b1;
      else if (mode == 1) res_if.ready <= ($urandom_range(0, 3) != 0);
      else if (mode == 2) res_if.ready <= ($urandom_range(0, 3) == 0);
      else res_if.ready <= ((count % period) == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $error("no beat on any channel for %0d cycles", StallLimit);
    $display("simulation failed");
    $finish;
  end

  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx);
    int gap;
    gap = 0;
    if (in_held || burst_left == 0) begin
      if (steady) begin
        burst_left = 1000;
      end else begin
        gap        = $urandom_range(0, 5);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 12);
      end
      // After a hold the valid line is already low, so a gap is forced before the next beat.
      if (in_held && gap == 0) gap = 1;
      if (gap > 0) begin
        if (!in_held) tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_held = 1'b0;
    end
    tick_if.valid   <= 1'b1;
    tick_if.cmd     <= cmd;
    tick_if.tx_byte <= tx;
    tick_if.sda_in  <= (slave_mode == SlaveNack) ? 1'b1 :
                       (slave_mode == SlaveAck)  ? 1'b0 : 1'($urandom_range(0, 1));
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  task automatic hold_input();
    if (!in_held) tick_if.valid <= 1'b0;
    in_held = 1'b1;
  endtask

  // The checker's view is complete once it has taken every tick beat sent.
  task automatic sync_model();
    wait (ticks_taken == ticks_sent);
  endtask

  task automatic issue(input logic [2:0] cmd, input logic [7:0] tx, input int mode);
    sync_model();
    while (line_busy) begin
      // Commands sent while the engine is busy must be ignored.
      if ($urandom_range(0, 9) == 0) send_tick(3'($urandom_range(0, 7)), 8'($urandom));
      else send_tick(CMD_NONE, 8'($urandom));
      sync_model();
    end
    slave_mode = (mode < 0) ? $urandom_range(0, 3) : mode;
    send_tick(cmd, tx);
  endtask

  task automatic quiesce();
    sync_model();
    while (line_busy) begin
      send_tick(CMD_NONE, 8'($urandom));
      sync_model();
    end
    hold_input();
    wait (waiting == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] half, input logic [3:0] limit);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_HALF_PERIOD;
    cfg_if.data  <= half;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    // Only the low nibble is the retry limit; the rest of the word is filler.
    cfg_if.index <= REG_RETRY_LIMIT;
    cfg_if.data  <= {12'($urandom), limit};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  task automatic random_transaction();
    int n;
    if ($urandom_range(0, 99) < 85) begin
      issue(CMD_START, 8'($urandom), SlaveAny);
      issue(CMD_WRITE, 8'($urandom), SlaveAny);
      n = $urandom_range(0, 3);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: issue(CMD_WRITE, 8'($urandom), SlaveAny);
          1: issue(CMD_READ_ACK, 8'($urandom), SlaveAny);
          default: begin
            issue(CMD_START, 8'($urandom), SlaveAny);
            issue(CMD_WRITE, 8'($urandom), SlaveAny);
          end
        endcase
      end
      if ($urandom_range(0, 1) == 1) issue(CMD_READ_NACK, 8'($urandom), SlaveAny);
      issue(CMD_STOP, 8'($urandom), SlaveAny);
    end else begin
      issue(3'($urandom_range(0, 7)), 8'($urandom), SlaveAny);
    end
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        hold_input();
        wait (waiting == 0);
      end
      random_transaction();
    end
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    steady     = 1'b0;
    in_held    = 1'b1;
    burst_left = 0;
    ticks_sent = 0;
    settings   = 0;
    slave_mode = SlaveNoisy;
    tick_if.valid   <= 1'b0;
    tick_if.cmd     <= CMD_NONE;
    tick_if.tx_byte <= 8'h00;
    tick_if.sda_in  <= 1'b1;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_HALF_PERIOD;
    cfg_if.data     <= 16'h0000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    issue(CMD_START, 8'h00, SlaveAck);
    issue(CMD_WRITE, 8'hFF, SlaveAck);
    send_tick(CMD_START, 8'h00);
    send_tick(CMD_READ_ACK, 8'h00);
    issue(CMD_WRITE, 8'h00, SlaveNack);
    issue(CMD_WRITE, 8'hA5, SlaveNoisy);
    issue(CMD_READ_ACK, 8'h00, SlaveNack);
    issue(CMD_READ_NACK, 8'hFF, SlaveAck);
    issue(CMD_START, 8'h5A, SlaveNoisy);
    issue(CMD_STOP, 8'h00, SlaveNoisy);
    issue(CMD_STOP, 8'hFF, SlaveNoisy);
    issue(CmdBadLow, 8'hC3, SlaveNoisy);
    issue(CmdBadHigh, 8'h3C, SlaveNoisy);

    // Zero half period and zero retry limit both act as one.
    quiesce();
    write_regs(16'd0, 4'd0);
    issue(CMD_START, 8'h00, SlaveAck);
    issue(CMD_WRITE, 8'h3C, SlaveNack);
    issue(CMD_READ_NACK, 8'h00, SlaveNoisy);
    issue(CMD_STOP, 8'h00, SlaveNoisy);
    random_phase(PhaseTicks);

    quiesce();
    write_regs(16'd1, 4'd15);
    random_phase(PhaseTicks);

    // Full-scale half period: a start fed without idling stays in its first phase,
    // and the shorter half period written next lets it finish.
    quiesce();
    write_regs(16'hFFFF, 4'd1);
    steady = 1'b1;
    issue(CMD_START, 8'($urandom), SlaveNoisy);
    repeat (40) send_tick(CMD_NONE, 8'($urandom));
    hold_input();
    wait (waiting == 0);
    repeat (8) @(posedge clk);
    steady = 1'b0;

    write_regs(16'd3, 4'd2);
    random_phase(PhaseTicks);

    quiesce();
    write_regs(16'($urandom_range(1, 4)), 4'($urandom_range(1, 15)));
    random_phase(PhaseTicks);

    quiesce();
    write_regs(HALF_PERIOD_RST, RETRY_LIMIT_RST);
    random_phase(PhaseTicks);

    quiesce();
    $display("Covered %0d tick beats, %0d completed commands, %0d writes given up on nack.",
             ticks_taken, cmds_done, write_fails);
    $display("Ran under %0d register settings, zero and full-scale half periods among them.",
             settings);
    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
